FILE: rtl/apg_pkg.sv
// ----------------------------------------------------------------------------
// apg_pkg
// Shared types, constants and codes for the arc point generator.
// ----------------------------------------------------------------------------
package apg_pkg;

    localparam int MAX_SEGMENTS_DEF    = 63;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic [16:0] FULL_TURN  = 17'd65536;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam int          TAYLOR_TERMS = 23;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_SEGMENTS = 2'd1;
    localparam logic [1:0] REG_SPAN     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_DIV,
        ST_TERM_MUL,
        ST_TERM_DIV,
        ST_TRIG_ROUND,
        ST_EMIT,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_ROT_D
    } apg_state_t;

endpackage

FILE: rtl/apg_divider.sv
// ----------------------------------------------------------------------------
// apg_divider
// Restoring divider, one quotient bit per cycle; unsigned 40 by 6 bits.
// ----------------------------------------------------------------------------
module apg_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [39:0]           dividend,
    input  logic [5:0]            divisor,
    output logic                  done,
    output logic [39:0]           quotient
);
    import apg_pkg::*;

    logic [39:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [6:0]  trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[5:0], quo_reg[39]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = 6'd40;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/apg_mul.sv
// ----------------------------------------------------------------------------
// apg_mul
// Shared registered signed multiplier, 33 by 33 bits.
// ----------------------------------------------------------------------------
module apg_mul
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);
    import apg_pkg::*;

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 66'(a) * 66'(b);
    end

    assign p = p_reg;
endmodule

FILE: rtl/arc_point_generator.sv
// ----------------------------------------------------------------------------
// arc_point_generator
// Emits the vertices of a circular arc by repeated rotation of (radius, 0).
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         start & !busy      start_req
// config    in         cfg_valid&ready    cfg_index, cfg_data
// point     out        point_valid        point_x, point_y, point_index, last_point
//
// Setup: the angle, then the step divide, then per Taylor term a product on
// the shared multiplier and a divide on the shared divider (23 terms), before
// the first point leaves. Each further point takes an emit and a rotation on
// the multiplier. Up to 64 points. Reset clears control and sets the config
// registers to their defaults. Points cannot be stalled; busy holds off requests.
// ----------------------------------------------------------------------------
module arc_point_generator
#(
    parameter int MAX_SEGMENTS    = apg_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_FRAC_BITS = apg_pkg::COORD_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               start_req,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               point_valid,
    output logic signed [24:0] point_x,
    output logic signed [24:0] point_y,
    output logic [5:0]         point_index,
    output logic               last_point
);
    import apg_pkg::*;

    localparam logic [23:0] MIN_RADIUS =
        24'(((64'd1 << COORD_FRAC_BITS) + 64'd99) / 64'd100);
    localparam logic [5:0] MAX_SEG = 6'(MAX_SEGMENTS);
    localparam logic signed [26:0] CUR_LIM = 27'sd33554431;
    localparam logic signed [25:0] OUT_LIM = 26'sd16777215;

    logic [23:0] radius_reg;
    logic [5:0]  seg_reg;
    logic [16:0] span_reg;

    apg_state_t state_reg, state_next;

    logic signed [26:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] cos_reg, cos_next, sin_reg, sin_next;
    logic [6:0]  left_reg, left_next;
    logic [5:0]  idx_reg, idx_next;
    logic [39:0] theta_reg, theta_next;
    logic [39:0] term_reg, term_next;
    logic signed [33:0] c_reg, c_next, s_reg, s_next;
    logic [4:0]  k_reg, k_next;
    logic signed [60:0] acc_reg, acc_next;
    logic        last_div_reg, last_div_next;

    logic               out_v_reg, out_v_next;
    logic signed [24:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [5:0]         oi_reg, oi_next;
    logic               ol_reg, ol_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic               div_start;
    logic               div_done;
    logic [39:0]        div_n, div_q;
    logic [5:0]         div_d;

    apg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    apg_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
        .divisor(div_d), .done(div_done), .quotient(div_q)
    );

    function automatic logic signed [60:0] rnd_sh(input logic signed [60:0] v,
                                                  input int n);
        logic [60:0] m;
        logic [60:0] r;
        begin
            m = v[60] ? 61'(-v) : 61'(v);
            r = (m + (61'd1 << (n - 1))) >> n;
            rnd_sh = v[60] ? 61'(-r) : 61'(r);
        end
    endfunction

    function automatic logic signed [26:0] sat_cur(input logic signed [60:0] v);
        begin
            if (v > 61'(CUR_LIM))
                sat_cur = CUR_LIM;
            else if (v < -61'(CUR_LIM))
                sat_cur = -CUR_LIM;
            else
                sat_cur = 27'(v);
        end
    endfunction

    function automatic logic signed [24:0] out_of(input logic signed [26:0] v);
        logic signed [60:0] r;
        begin
            r = rnd_sh(61'(v), 1);
            if (r > 61'(OUT_LIM))
                out_of = 25'(OUT_LIM);
            else if (r < -61'(OUT_LIM))
                out_of = 25'(-OUT_LIM);
            else
                out_of = 25'(r);
        end
    endfunction

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 24'd65536;
            seg_reg    <= 6'd16;
            span_reg   <= FULL_TURN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS:
                    radius_reg <= (cfg_data < MIN_RADIUS) ? MIN_RADIUS : cfg_data;
                REG_SEGMENTS:
                begin
                    if (cfg_data[5:0] < 6'd3)
                        seg_reg <= 6'd3;
                    else if (cfg_data[5:0] > MAX_SEG)
                        seg_reg <= MAX_SEG;
                    else
                        seg_reg <= cfg_data[5:0];
                end
                REG_SPAN:
                begin
                    if (cfg_data[16:0] == 17'd0)
                        span_reg <= 17'd1;
                    else if (cfg_data[16:0] > FULL_TURN)
                        span_reg <= FULL_TURN;
                    else
                        span_reg <= cfg_data[16:0];
                end
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        cos_next      = cos_reg;
        sin_next      = sin_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        theta_next    = theta_reg;
        term_next     = term_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        last_div_next = last_div_reg;
        out_v_next    = 1'b0;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oi_next       = oi_reg;
        ol_next       = ol_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_n         = '0;
        div_d         = seg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start && start_req)
                begin
                    state_next = ST_ANGLE;
                    x_next     = 27'(signed'({3'b000, radius_reg}) * 2);
                    y_next     = '0;
                    left_next  = {1'b0, seg_reg} + ((span_reg == FULL_TURN) ? 7'd0 : 7'd1);
                    idx_next   = '0;
                end
            end
            ST_ANGLE:
            begin
                // span * 2pi, 17 x 33 bits, then round away 16 bits
                theta_next = 40'(((58'(span_reg) * 58'(TWO_PI_Q30)) + 58'd32768) >> 16);
                state_next = ST_DIV;
                last_div_next = 1'b1;
            end
            ST_DIV:
            begin
                if (last_div_reg)
                begin
                    div_start     = 1'b1;
                    div_n         = theta_reg + 40'(seg_reg >> 1);
                    last_div_next = 1'b0;
                end
                else if (div_done)
                begin
                    theta_next = div_q;
                    term_next  = 40'd1 << 30;
                    c_next     = 34'sd1 << 30;
                    s_next     = '0;
                    k_next     = 5'd1;
                    state_next = ST_TERM_MUL;
                    last_div_next = 1'b1;
                end
            end
            ST_TERM_MUL:
            begin
                mul_a = 33'(term_reg);
                mul_b = 33'(theta_reg);
                if (!last_div_reg)
                begin
                    div_start = 1'b1;
                    div_n = 40'(mul_p >>> 30);
                    div_d = 6'(k_reg);
                    state_next = ST_TERM_DIV;
                end
                last_div_next = 1'b0;
            end
            ST_TERM_DIV:
            begin
                div_d = 6'(k_reg);
                if (div_done)
                begin
                    term_next = div_q;
                    case (k_reg[1:0])
                        2'd1: s_next = s_reg + 34'(div_q);
                        2'd2: c_next = c_reg - 34'(div_q);
                        2'd3: s_next = s_reg - 34'(div_q);
                        default: c_next = c_reg + 34'(div_q);
                    endcase
                    last_div_next = 1'b1;
                    if (k_reg == 5'(TAYLOR_TERMS))
                        state_next = ST_TRIG_ROUND;
                    else
                    begin
                        k_next     = k_reg + 5'd1;
                        state_next = ST_TERM_MUL;
                    end
                end
            end
            ST_TRIG_ROUND:
            begin
                cos_next   = 18'(rnd_sh(61'(c_reg), 14));
                sin_next   = 18'(rnd_sh(61'(s_reg), 14));
                last_div_next = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_v_next = 1'b1;
                ox_next    = out_of(x_reg);
                oy_next    = out_of(y_reg);
                oi_next    = idx_reg;
                ol_next    = (left_reg == 7'd1);
                idx_next   = idx_reg + 6'd1;
                left_next  = left_reg - 7'd1;
                state_next = (left_reg == 7'd1) ? ST_IDLE : ST_ROT_A;
            end
            ST_ROT_A:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(cos_reg);
                state_next = ST_ROT_B;
            end
            ST_ROT_B:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(sin_reg);
                acc_next = 61'(mul_p);
                state_next = ST_ROT_C;
            end
            ST_ROT_C:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(sin_reg);
                acc_next = acc_reg - 61'(mul_p);
                state_next = ST_ROT_D;
            end
            ST_ROT_D:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(cos_reg);
                acc_next = 61'(mul_p);
                x_next = sat_cur(rnd_sh(acc_reg, 16));
                state_next = ST_ROT_D;
                if (last_div_reg)
                begin
                    y_next = sat_cur(rnd_sh(acc_reg + 61'(mul_p), 16));
                    last_div_next = 1'b0;
                    x_next = x_reg;
                    state_next = ST_EMIT;
                end
                else
                    last_div_next = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            left_reg     <= '0;
            out_v_reg    <= 1'b0;
            last_div_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            left_reg     <= left_next;
            out_v_reg    <= out_v_next;
            last_div_reg <= last_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
        idx_reg   <= idx_next;
        theta_reg <= theta_next;
        term_reg  <= term_next;
        c_reg     <= c_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oi_reg    <= oi_next;
        ol_reg    <= ol_next;
    end

    assign point_valid = out_v_reg;
    assign point_x     = ox_reg;
    assign point_y     = oy_reg;
    assign point_index = oi_reg;
    assign last_point  = ol_reg;
endmodule

FILE: verif/arc_point_checker.sv
// ----------------------------------------------------------------------------
// arc_point_checker
// Watches the request, register and point channels of the arc point
// generator. Keeps its own copy of the registers, works out the vertices of
// every accepted request by fixed-point Taylor trig and chained rotation,
// and compares each emitted point with the oldest vertex still outstanding.
// ----------------------------------------------------------------------------
module arc_point_checker
    import apg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               start_req,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               point_valid,
    input  logic signed [24:0] point_x,
    input  logic signed [24:0] point_y,
    input  logic [5:0]         point_index,
    input  logic               last_point,
    output int                 fail_count,
    output int                 vertices_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic [5:0]         idx;
        logic               last;
    } vertex_t;

    localparam longint CUR_MAX = 64'sd33554431;
    localparam longint OUT_MAX = 64'sd16777215;

    vertex_t           vertex_q[$];
    logic [23:0]       radius_reg;
    logic [5:0]        segs_reg;
    logic [16:0]       span_reg;

    assign vertices_due = vertex_q.size();

    function automatic longint round_half(longint v, int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v < 0)
            return -((-v + half) >>> n);
        return (v + half) >>> n;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic predict_arc();
        longint unsigned ang, theta, term;
        longint          c, s, cs, sn, cx, cy, nx, ny;
        int              left, n;
        vertex_t         v;
        ang   = (longint'(span_reg) * 64'd6746518852 + 64'd32768) >> 16;
        theta = (ang + segs_reg / 2) / segs_reg;
        term  = 64'd1 << 30;
        c     = longint'(1) <<< 30;
        s     = 0;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * theta) >> 30) / k;
            case (k % 4)
                1: s += longint'(term);
                2: c -= longint'(term);
                3: s -= longint'(term);
                default: c += longint'(term);
            endcase
        end
        cs   = round_half(c, 14);
        sn   = round_half(s, 14);
        cx   = longint'(radius_reg) * 2;
        cy   = 0;
        left = segs_reg + ((span_reg == FULL_TURN) ? 0 : 1);
        n    = 0;
        while (left > 0)
        begin
            v.x    = clip(round_half(cx, 1), OUT_MAX);
            v.y    = clip(round_half(cy, 1), OUT_MAX);
            v.idx  = n;
            v.last = (left == 1);
            vertex_q.insert(vertex_q.size(), v);
            n++;
            if (left > 1)
            begin
                nx = cx * cs - cy * sn;
                ny = cx * sn + cy * cs;
                cx = clip(round_half(nx, 16), CUR_MAX);
                cy = clip(round_half(ny, 16), CUR_MAX);
            end
            left--;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 24'd65536;
            segs_reg   <= 6'd16;
            span_reg   <= FULL_TURN;
            fail_count <= 0;
            vertex_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RADIUS:   radius_reg <= (cfg_data < 24'd656) ? 24'd656 : cfg_data;
                    REG_SEGMENTS: segs_reg <= (cfg_data[5:0] < 6'd3) ? 6'd3 : cfg_data[5:0];
                    REG_SPAN:     span_reg <= (cfg_data[16:0] == 17'd0) ? 17'd1 :
                                              (cfg_data[16:0] > FULL_TURN) ? FULL_TURN :
                                              cfg_data[16:0];
                    default: ;
                endcase
            end
            if (point_valid)
            begin
                if (vertex_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected point x=%0d y=%0d idx=%0d last=%0b",
                                 $realtime, point_x, point_y, point_index, last_point);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    vertex_t e;
                    e = vertex_q.pop_front();
                    if (e.x !== point_x || e.y !== point_y || e.idx !== point_index ||
                        e.last !== last_point)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: point mismatch exp x=%0d y=%0d idx=%0d last=%0b",
                                      " got x=%0d y=%0d idx=%0d last=%0b"},
                                     $realtime, e.x, e.y, e.idx, e.last,
                                     point_x, point_y, point_index, last_point);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy && start_req)
                predict_arc();
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives arc requests and register writes into the arc point generator in
// bursts with random gaps; the checker predicts and compares every vertex.
// Settings cover low clamps, both span clamps, full and partial spans.
// ----------------------------------------------------------------------------
module testbench;
    import apg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1300;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               start_req = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_RADIUS;
    logic [23:0]        cfg_data = '0;
    logic               point_valid;
    logic signed [24:0] point_x;
    logic signed [24:0] point_y;
    logic [5:0]         point_index;
    logic               last_point;
    int                 fail_count;
    int                 vertices_due;
    int                 idle_cycles = 0;

    always #6 clk = ~clk;

    arc_point_generator dut (.*);

    arc_point_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || point_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(logic req);
        start     = 1'b1;
        start_req = req;
        while (busy) @(negedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (vertices_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        while (!cfg_ready) @(negedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_arc(logic [23:0] r, logic [23:0] n, logic [23:0] a);
        drain();
        write_reg(REG_RADIUS, r);
        write_reg(REG_SEGMENTS, n);
        write_reg(REG_SPAN, a);
    endtask

    initial
    begin
        int burst;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(1'b1);
        send_request(1'b0);
        set_arc(24'd0, 24'd0, 24'd0);
        send_request(1'b1);
        set_arc(24'hFFFFFF, 24'd63, 24'd65536);
        send_request(1'b1);
        set_arc(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(1'b1);
        set_arc(24'd655, 24'd2, 24'd65535);
        send_request(1'b1);
        set_arc(24'd656, 24'd3, 24'd65537);
        send_request(1'b1);
        set_arc(24'd100000, 24'd1, 24'd32768);
        send_request(1'b1);
        send_request(1'b1);
        drain();
        write_reg(REG_NONE, 24'h5A5A5A);
        send_request(1'b1);

        for (int phase = 0; phase < 40; phase++)
        begin
            set_arc($urandom, $urandom, ($urandom_range(0, 3) == 0) ? 24'd65536 : $urandom);
            burst = $urandom_range(1, 6);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 40)) @(negedge clk);
                send_request($urandom_range(0, 9) != 0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: arc_point_generator.f
rtl/apg_pkg.sv
rtl/apg_divider.sv
rtl/apg_mul.sv
rtl/arc_point_generator.sv
verif/arc_point_checker.sv
verif/testbench.sv
